>>> rtl/core/sig_pkg.sv
// sig_pkg: shared types and constants for the split information gain block.
// Payload structs, controller states, command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package sig_pkg;

	localparam int HIST_W   = 40;
	localparam int FRAC_W   = 16;
	localparam int MAN_W    = 32;
	localparam int WEIGHT_W = 24;
	localparam int GAIN_W   = 24;
	localparam int LABEL_W  = 3;
	localparam int ACT_W    = 4;
	localparam int ONE_Q8   = 256;

	localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;
	localparam logic REG_ACTIVE_SEL = 1'b0;

	localparam logic STATUS_VALID = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic [LABEL_W-1:0]  class_label;
		logic [WEIGHT_W-1:0] sample_weight;
		logic                goes_left;
		logic                last_sample;
	} sample_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain;
		logic                     status;
	} result_t;

	typedef enum logic [1:0] {H_WHOLE, H_LEFT, H_RIGHT} hist_sel_t;
	typedef enum logic [1:0] {MD_MUL, MD_MAC, MD_DIV} md_op_t;
	typedef enum logic [1:0] {MS_ENT, MS_WL, MS_WR} md_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SUM, ST_CHECK,
		ST_DEN_GO, ST_DEN_WAIT, ST_NUM_GO, ST_NUM_WAIT,
		ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_NEXT,
		ST_SHIFT, ST_WL_GO, ST_WL_WAIT, ST_WR_GO, ST_WR_WAIT,
		ST_WDIV_GO, ST_WDIV_WAIT, ST_EMIT
	} state_t;

	typedef struct packed {
		logic      accept;
		logic      sum_clr;
		logic      sum_add;
		hist_sel_t sel;
		logic      lg_go;
		logic      lg_den;
		logic      lden_store;
		logic      d_store;
		logic      md_go;
		md_op_t    md_op;
		md_sel_t   md_sel;
		logic      acc_add;
		logic      ent_store;
		logic      ab_load;
		logic      ab_shift;
		logic      emit;
	} cmd_t;

	typedef struct packed {
		logic lg_done;
		logic md_done;
		logic empty;
		logic ab_fits;
	} sts_t;

endpackage

>>> rtl/core/split_information_gain.sv
// split_information_gain: top level, configuration register and assertions.
// Depends on sig_pkg, sig_ctrl, sig_datapath.
//
// Usage: one sample transfers on each clock edge with start high and busy low,
// so samples stream at one per cycle into the left/right class histograms.
// A sample with last_sample set closes the set; busy then rises and the
// scoring sequencer runs: a sum pass over the n active labels, then
// for the whole, left and right histograms one log2 of the total and, per
// label, one log2 (normalise shifts, then squaring steps), one serial
// multiply and one serial divide of QW bits each (QW = 25 for 8 labels),
// all on the shared log2 and multiply/divide units.
// An empty set or side skips the entropy work.
// The result shows on result for exactly one cycle with done high, the first
// cycle with busy low; the receiver cannot stall it. Histograms clear before it.
// Reset clears both histograms and sets active_labels to 8.
// APB: active_labels at byte address 0; write only while idle (not enforced).
`timescale 1ns / 1ps

module split_information_gain #(
	parameter int MAX_LABELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sig_pkg::sample_t  sample,
	output logic              done,
	output sig_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int LW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

	logic [sig_pkg::ACT_W-1:0] act_q;
	logic [LW-1:0]             nm1, idx;
	sig_pkg::cmd_t             cmd;
	sig_pkg::sts_t             sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= sig_pkg::ACT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == sig_pkg::REG_ACTIVE_SEL)) begin
			act_q <= pwdata[sig_pkg::ACT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == sig_pkg::REG_ACTIVE_SEL) ? 32'(act_q) : '0;

	always_comb begin
		if (act_q == '0) begin
			nm1 = '0;
		end else if (32'(act_q) > MAX_LABELS) begin
			nm1 = LW'(MAX_LABELS - 1);
		end else begin
			nm1 = LW'(act_q - 1'b1);
		end
	end

	sig_ctrl #(.MAX_LABELS(MAX_LABELS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (sample.last_sample),
		.nm1    (nm1),
		.sts    (sts),
		.cmd    (cmd),
		.idx    (idx),
		.busy   (busy)
	);

	sig_datapath #(.MAX_LABELS(MAX_LABELS)) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.idx    (idx),
		.sample (sample),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a scoring pass");

	a_busy_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && sample.last_sample))
		else $error("scoring started without a last sample");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == sig_pkg::STATUS_EMPTY)) |-> (result.gain == '0))
		else $error("empty status with non-zero gain");

endmodule

>>> rtl/core/sig_log2.sv
// sig_log2: iterative base-2 logarithm, Q.16 result.
// Normalises one bit a cycle, then 16 squaring steps on a 32x32 multiplier.
// Depends on sig_pkg.
`timescale 1ns / 1ps

module sig_log2 #(
	parameter int DW = 45
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   go,
	input  logic [DW-1:0]                          x,
	output logic                                   done,
	output logic [sig_pkg::FRAC_W+$clog2(DW)-1:0]  y
);

	localparam int EW   = $clog2(DW);
	localparam int MW   = sig_pkg::MAN_W;
	localparam int SQ_W = 2 * MW;
	localparam int CW   = $clog2(sig_pkg::FRAC_W);
	localparam int FW   = sig_pkg::FRAC_W;

	logic          norm_q, sq_run_q, half_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] m_q;
	logic [EW-1:0] e_q;
	logic [MW-1:0] man_q;
	logic [SQ_W-1:0] sq_q;
	logic [FW-1:0] frac_q;
	logic [MW:0]   t;
	logic          last_step;

	assign t = sq_q[SQ_W-1:MW-1];
	assign last_step = sq_run_q && half_q && (cnt_q == CW'(FW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q   <= 1'b0;
			sq_run_q <= 1'b0;
			half_q   <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= last_step;
			if (go) begin
				norm_q <= 1'b1;
			end else if (norm_q && m_q[DW-1]) begin
				norm_q   <= 1'b0;
				sq_run_q <= 1'b1;
				half_q   <= 1'b0;
				cnt_q    <= '0;
			end else if (sq_run_q) begin
				half_q <= !half_q;
				if (half_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						sq_run_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_q <= x;
			e_q <= EW'(DW - 1);
		end else if (norm_q) begin
			if (m_q[DW-1]) begin
				man_q <= m_q[DW-1 -: MW];
			end else begin
				m_q <= m_q << 1;
				e_q <= e_q - 1'b1;
			end
		end else if (sq_run_q) begin
			if (!half_q) begin
				sq_q <= SQ_W'(man_q) * SQ_W'(man_q);
			end else begin
				frac_q <= {frac_q[FW-2:0], t[MW]};
				man_q  <= t[MW] ? t[MW:1] : t[MW-1:0];
			end
		end
	end

	assign done = done_q;
	assign y    = {e_q, frac_q};

endmodule

>>> rtl/core/sig_muldiv.sv
// sig_muldiv: shared shift-add multiplier and restoring divider.
// One multiplier bit or one quotient bit a cycle; the product is the dividend.
// Depends on sig_pkg.
`timescale 1ns / 1ps

module sig_muldiv #(
	parameter int VW = 45,
	parameter int QW = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  sig_pkg::md_op_t        op,
	input  logic [VW-1:0]          mcand,
	input  logic [QW-1:0]          mplier,
	input  logic [VW-1:0]          dvs,
	output logic                   done,
	output logic [QW-1:0]          quot
);

	localparam int PW   = VW + QW;
	localparam int CNTW = $clog2(QW + 1);

	logic            run_q, div_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [PW-1:0]   prod_q, mc_q;
	logic [QW-1:0]   mp_q, quot_q;
	logic [VW-1:0]   dvs_q, rem_q;
	logic [VW:0]     t, diff;
	logic            qbit, last_step;

	assign t         = {rem_q, prod_q[QW-1]};
	assign diff      = t - {1'b0, dvs_q};
	assign qbit      = (t >= {1'b0, dvs_q});
	assign last_step = run_q && (cnt_q == CNTW'(QW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= last_step;
			if (go) begin
				run_q <= 1'b1;
				div_q <= (op == sig_pkg::MD_DIV);
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			unique case (op)
				sig_pkg::MD_MUL: begin
					prod_q <= '0;
					mc_q   <= PW'(mcand);
					mp_q   <= mplier;
				end
				sig_pkg::MD_MAC: begin
					mc_q <= PW'(mcand);
					mp_q <= mplier;
				end
				sig_pkg::MD_DIV: begin
					dvs_q <= dvs;
					rem_q <= prod_q[PW-1:QW];
				end
				default: begin
					mp_q <= '0;
				end
			endcase
		end else if (run_q) begin
			if (div_q) begin
				rem_q  <= qbit ? diff[VW-1:0] : t[VW-1:0];
				prod_q <= prod_q << 1;
				quot_q <= {quot_q[QW-2:0], qbit};
			end else begin
				if (mp_q[0]) begin
					prod_q <= prod_q + mc_q;
				end
				mc_q <= mc_q << 1;
				mp_q <= mp_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> rtl/core/sig_datapath.sv
// sig_datapath: class histograms, sums, entropy and weighting registers.
// Holds the log2 unit and the shared multiply/divide unit.
// Depends on sig_pkg, sig_log2, sig_muldiv.
`timescale 1ns / 1ps

module sig_datapath #(
	parameter int MAX_LABELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sig_pkg::cmd_t        cmd,
	input  logic [((MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1)-1:0] idx,
	input  sig_pkg::sample_t     sample,
	output sig_pkg::sts_t        sts,
	output logic                 done,
	output sig_pkg::result_t     result
);

	localparam int LW  = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam int HBW = sig_pkg::HIST_W;
	localparam int SW  = HBW + LW;
	localparam int TW  = SW + 1;
	localparam int DW  = TW + 1;
	localparam int LGW = sig_pkg::FRAC_W + $clog2(DW);
	localparam int HW  = LGW + LW;
	localparam int GW  = sig_pkg::GAIN_W;
	localparam logic signed [HW:0] GMAX = (HW+1)'(2**(GW-1) - 1);
	localparam logic signed [HW:0] GMIN = (HW+1)'(-(2**(GW-1)));

	logic [HBW-1:0] lhist_q [MAX_LABELS];
	logic [HBW-1:0] rhist_q [MAX_LABELS];
	logic [LW-1:0]  addr;
	logic [HBW-1:0] lrd, rrd, slot, upd;
	logic [HBW:0]   sum_w;
	logic           label_ok;

	logic [SW-1:0]  sl_q, sr_q, a_q, b_q;
	logic [TW-1:0]  s_tot, ab_sum, h_sel, t_sel;
	logic [DW-1:0]  num, den, lg_x;
	logic [LGW-1:0] lg_y, lden_q, d_q;
	logic           lg_done;
	logic [HW-1:0]  acc_q, hb_q, hl_q, hr_q, quot;
	logic           md_done;
	logic [DW-1:0]  mcand, dvs;
	logic [HW-1:0]  mplier;
	logic signed [HW:0] diff, gain_sat;
	logic           done_q;
	sig_pkg::result_t result_q;

	assign addr     = cmd.accept ? LW'(sample.class_label) : idx;
	assign lrd      = lhist_q[addr];
	assign rrd      = rhist_q[addr];
	assign label_ok = (32'(sample.class_label) < MAX_LABELS);
	assign slot     = sample.goes_left ? lrd : rrd;
	assign sum_w    = {1'b0, slot} + (HBW+1)'(sample.sample_weight);
	assign upd      = sum_w[HBW] ? '1 : sum_w[HBW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LABELS; i++) begin
				lhist_q[i] <= '0;
				rhist_q[i] <= '0;
			end
		end else if (cmd.emit) begin
			for (int i = 0; i < MAX_LABELS; i++) begin
				lhist_q[i] <= '0;
				rhist_q[i] <= '0;
			end
		end else if (cmd.accept && label_ok) begin
			if (sample.goes_left) begin
				lhist_q[addr] <= upd;
			end else begin
				rhist_q[addr] <= upd;
			end
		end
	end

	assign s_tot  = {1'b0, sl_q} + {1'b0, sr_q};
	assign ab_sum = {1'b0, a_q} + {1'b0, b_q};

	always_comb begin
		unique case (cmd.sel)
			sig_pkg::H_LEFT: begin
				h_sel = TW'(lrd);
				t_sel = TW'(sl_q);
			end
			sig_pkg::H_RIGHT: begin
				h_sel = TW'(rrd);
				t_sel = TW'(sr_q);
			end
			default: begin
				h_sel = TW'(lrd) + TW'(rrd);
				t_sel = s_tot;
			end
		endcase
	end

	assign num  = DW'(h_sel) + DW'(sig_pkg::ONE_Q8);
	assign den  = DW'(t_sel) + DW'(sig_pkg::ONE_Q8);
	assign lg_x = cmd.lg_den ? den : num;

	sig_log2 #(.DW(DW)) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.lg_go),
		.x      (lg_x),
		.done   (lg_done),
		.y      (lg_y)
	);

	always_comb begin
		unique case (cmd.md_sel)
			sig_pkg::MS_WL: begin
				mcand  = DW'(a_q);
				mplier = hl_q;
				dvs    = DW'(ab_sum);
			end
			sig_pkg::MS_WR: begin
				mcand  = DW'(b_q);
				mplier = hr_q;
				dvs    = DW'(ab_sum);
			end
			default: begin
				mcand  = num;
				mplier = HW'(d_q);
				dvs    = den;
			end
		endcase
	end

	sig_muldiv #(.VW(DW), .QW(HW)) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.md_go),
		.op     (cmd.md_op),
		.mcand  (mcand),
		.mplier (mplier),
		.dvs    (dvs),
		.done   (md_done),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sl_q <= '0;
			sr_q <= '0;
		end else if (cmd.sum_add) begin
			sl_q <= sl_q + SW'(lrd);
			sr_q <= sr_q + SW'(rrd);
		end
		if (cmd.lden_store) begin
			lden_q <= lg_y;
			acc_q  <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + quot;
		end
		if (cmd.d_store) begin
			d_q <= lden_q - lg_y;
		end
		if (cmd.ent_store) begin
			unique case (cmd.sel)
				sig_pkg::H_LEFT:  hl_q <= acc_q;
				sig_pkg::H_RIGHT: hr_q <= acc_q;
				default:          hb_q <= acc_q;
			endcase
		end
		if (cmd.ab_load) begin
			a_q <= sl_q;
			b_q <= sr_q;
		end else if (cmd.ab_shift) begin
			a_q <= a_q >> 1;
			b_q <= b_q >> 1;
		end
	end

	assign diff = $signed({1'b0, hb_q}) - $signed({1'b0, quot});

	always_comb begin
		if (diff > GMAX) begin
			gain_sat = GMAX;
		end else if (diff < GMIN) begin
			gain_sat = GMIN;
		end else begin
			gain_sat = diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (sts.empty) begin
				result_q.gain   <= '0;
				result_q.status <= sig_pkg::STATUS_EMPTY;
			end else begin
				result_q.gain   <= GW'(gain_sat);
				result_q.status <= sig_pkg::STATUS_VALID;
			end
		end
	end

	assign sts.lg_done = lg_done;
	assign sts.md_done = md_done;
	assign sts.empty   = (sl_q == '0) || (sr_q == '0);
	assign sts.ab_fits = (ab_sum[TW-1:HBW] == '0);
	assign done        = done_q;
	assign result      = result_q;

endmodule

>>> rtl/core/sig_ctrl.sv
// sig_ctrl: scoring sequencer for the split information gain block.
// Walks labels and histograms, issues commands to sig_datapath.
// Depends on sig_pkg.
`timescale 1ns / 1ps

module sig_ctrl #(
	parameter int MAX_LABELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 last,
	input  logic [((MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1)-1:0] nm1,
	input  sig_pkg::sts_t        sts,
	output sig_pkg::cmd_t        cmd,
	output logic [((MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1)-1:0] idx,
	output logic                 busy
);

	localparam int LW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

	sig_pkg::state_t    state_q, state_d;
	sig_pkg::hist_sel_t sel_q, sel_d;
	logic [LW-1:0]      idx_q, idx_d;
	logic               idx_last;

	assign idx_last = (idx_q == nm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sig_pkg::ST_IDLE;
			sel_q   <= sig_pkg::H_WHOLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		idx_d   = idx_q;
		unique case (state_q)
			sig_pkg::ST_IDLE: begin
				idx_d = '0;
				if (start && last) begin
					state_d = sig_pkg::ST_SUM;
				end
			end
			sig_pkg::ST_SUM: begin
				idx_d = idx_q + 1'b1;
				if (idx_last) begin
					idx_d   = '0;
					state_d = sig_pkg::ST_CHECK;
				end
			end
			sig_pkg::ST_CHECK: begin
				sel_d   = sig_pkg::H_WHOLE;
				idx_d   = '0;
				state_d = sts.empty ? sig_pkg::ST_EMIT : sig_pkg::ST_DEN_GO;
			end
			sig_pkg::ST_DEN_GO:   state_d = sig_pkg::ST_DEN_WAIT;
			sig_pkg::ST_DEN_WAIT: if (sts.lg_done) state_d = sig_pkg::ST_NUM_GO;
			sig_pkg::ST_NUM_GO:   state_d = sig_pkg::ST_NUM_WAIT;
			sig_pkg::ST_NUM_WAIT: if (sts.lg_done) state_d = sig_pkg::ST_MUL_GO;
			sig_pkg::ST_MUL_GO:   state_d = sig_pkg::ST_MUL_WAIT;
			sig_pkg::ST_MUL_WAIT: if (sts.md_done) state_d = sig_pkg::ST_DIV_GO;
			sig_pkg::ST_DIV_GO:   state_d = sig_pkg::ST_DIV_WAIT;
			sig_pkg::ST_DIV_WAIT: if (sts.md_done) state_d = sig_pkg::ST_NEXT;
			sig_pkg::ST_NEXT: begin
				if (!idx_last) begin
					idx_d   = idx_q + 1'b1;
					state_d = sig_pkg::ST_NUM_GO;
				end else begin
					idx_d = '0;
					unique case (sel_q)
						sig_pkg::H_WHOLE: begin
							sel_d   = sig_pkg::H_LEFT;
							state_d = sig_pkg::ST_DEN_GO;
						end
						sig_pkg::H_LEFT: begin
							sel_d   = sig_pkg::H_RIGHT;
							state_d = sig_pkg::ST_DEN_GO;
						end
						default: begin
							state_d = sig_pkg::ST_SHIFT;
						end
					endcase
				end
			end
			sig_pkg::ST_SHIFT:     if (sts.ab_fits) state_d = sig_pkg::ST_WL_GO;
			sig_pkg::ST_WL_GO:     state_d = sig_pkg::ST_WL_WAIT;
			sig_pkg::ST_WL_WAIT:   if (sts.md_done) state_d = sig_pkg::ST_WR_GO;
			sig_pkg::ST_WR_GO:     state_d = sig_pkg::ST_WR_WAIT;
			sig_pkg::ST_WR_WAIT:   if (sts.md_done) state_d = sig_pkg::ST_WDIV_GO;
			sig_pkg::ST_WDIV_GO:   state_d = sig_pkg::ST_WDIV_WAIT;
			sig_pkg::ST_WDIV_WAIT: if (sts.md_done) state_d = sig_pkg::ST_EMIT;
			sig_pkg::ST_EMIT:      state_d = sig_pkg::ST_IDLE;
			default:               state_d = sig_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.sel    = sel_q;
		cmd.md_op  = sig_pkg::MD_MUL;
		cmd.md_sel = sig_pkg::MS_ENT;
		unique case (state_q)
			sig_pkg::ST_IDLE: begin
				cmd.accept  = start;
				cmd.sum_clr = 1'b1;
			end
			sig_pkg::ST_SUM:   cmd.sum_add = 1'b1;
			sig_pkg::ST_CHECK: cmd.ab_load = 1'b1;
			sig_pkg::ST_DEN_GO: begin
				cmd.lg_go  = 1'b1;
				cmd.lg_den = 1'b1;
			end
			sig_pkg::ST_DEN_WAIT: begin
				cmd.lg_den     = 1'b1;
				cmd.lden_store = sts.lg_done;
			end
			sig_pkg::ST_NUM_GO:   cmd.lg_go = 1'b1;
			sig_pkg::ST_NUM_WAIT: cmd.d_store = sts.lg_done;
			sig_pkg::ST_MUL_GO:   cmd.md_go = 1'b1;
			sig_pkg::ST_DIV_GO: begin
				cmd.md_go = 1'b1;
				cmd.md_op = sig_pkg::MD_DIV;
			end
			sig_pkg::ST_DIV_WAIT: cmd.acc_add = sts.md_done;
			sig_pkg::ST_NEXT:     cmd.ent_store = idx_last;
			sig_pkg::ST_SHIFT:    cmd.ab_shift = !sts.ab_fits;
			sig_pkg::ST_WL_GO: begin
				cmd.md_go  = 1'b1;
				cmd.md_sel = sig_pkg::MS_WL;
			end
			sig_pkg::ST_WR_GO: begin
				cmd.md_go  = 1'b1;
				cmd.md_op  = sig_pkg::MD_MAC;
				cmd.md_sel = sig_pkg::MS_WR;
			end
			sig_pkg::ST_WDIV_GO: begin
				cmd.md_go  = 1'b1;
				cmd.md_op  = sig_pkg::MD_DIV;
				cmd.md_sel = sig_pkg::MS_WL;
			end
			sig_pkg::ST_EMIT: cmd.emit = 1'b1;
			default: cmd.sum_clr = 1'b0;
		endcase
	end

	assign idx  = idx_q;
	assign busy = (state_q != sig_pkg::ST_IDLE);

endmodule

>>> tb/split_information_gain_tb.sv
// split_information_gain_tb: self-checking bench for the split gain scorer.
// Streams labelled weighted samples, predicts histograms and Q8.16 gain, checks each result.
// Depends on sig_pkg and split_information_gain.
`timescale 1ns / 1ps

module split_information_gain_tb;

	localparam int NLAB = 8;
	localparam int STALL_LIMIT = 40000;
	localparam logic [2:0] ADDR_ACTIVE = 3'd0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sig_pkg::sample_t sample = '0;
	logic done;
	sig_pkg::result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	longint unsigned left_acc [NLAB];
	longint unsigned right_acc [NLAB];
	logic [3:0] labels_cfg;
	sig_pkg::result_t gain_q[$];
	int mismatches = 0;
	int idle_pct = 0;
	int stall_cnt = 0;

	split_information_gain #(.MAX_LABELS(NLAB)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	function automatic longint unsigned log2_q16(longint unsigned x);
		longint unsigned m;
		longint unsigned frac;
		int e;
		if (x == 0)
			return 0;
		frac = 0;
		e = 63;
		while (!x[e])
			e--;
		m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd2 << 31)) begin
				frac |= 1;
				m = m >> 1;
			end
		end
		return (longint'(e) << 16) | frac;
	endfunction

	function automatic longint unsigned entropy_q16(longint unsigned h [NLAB], int n,
			longint unsigned total);
		longint unsigned den;
		longint unsigned lden;
		longint unsigned num;
		longint unsigned acc;
		den = total + sig_pkg::ONE_Q8;
		lden = log2_q16(den);
		acc = 0;
		for (int l = 0; l < n; l++) begin
			num = h[l] + sig_pkg::ONE_Q8;
			acc += (num * (lden - log2_q16(num))) / den;
		end
		return acc;
	endfunction

	function automatic void clear_hists();
		for (int l = 0; l < NLAB; l++) begin
			left_acc[l] = 0;
			right_acc[l] = 0;
		end
	endfunction

	// Histogram update; on the closing sample, score the split and queue the result.
	function automatic void score_sample(sig_pkg::sample_t s);
		longint unsigned whole [NLAB];
		longint unsigned sl, sr, a, b, hb, hl, hr, q, v;
		longint g;
		int n;
		sig_pkg::result_t r;
		v = s.goes_left ? left_acc[s.class_label] : right_acc[s.class_label];
		v += s.sample_weight;
		if (v > 64'hFF_FFFF_FFFF)
			v = 64'hFF_FFFF_FFFF;
		if (s.goes_left)
			left_acc[s.class_label] = v;
		else
			right_acc[s.class_label] = v;
		if (!s.last_sample)
			return;
		n = labels_cfg;
		if (n == 0)
			n = 1;
		if (n > NLAB)
			n = NLAB;
		sl = 0;
		sr = 0;
		for (int l = 0; l < NLAB; l++)
			whole[l] = left_acc[l] + right_acc[l];
		for (int l = 0; l < n; l++) begin
			sl += left_acc[l];
			sr += right_acc[l];
		end
		r.gain = '0;
		r.status = sig_pkg::STATUS_VALID;
		if (sl == 0 || sr == 0) begin
			r.status = sig_pkg::STATUS_EMPTY;
		end else begin
			hb = entropy_q16(whole, n, sl + sr);
			hl = entropy_q16(left_acc, n, sl);
			hr = entropy_q16(right_acc, n, sr);
			a = sl;
			b = sr;
			while (a + b > 64'hFF_FFFF_FFFF) begin
				a = a >> 1;
				b = b >> 1;
			end
			q = (hl * a + hr * b) / (a + b);
			g = longint'(hb) - longint'(q);
			if (g > 8388607)
				g = 8388607;
			if (g < -8388608)
				g = -8388608;
			r.gain = g[23:0];
		end
		gain_q = {gain_q, r};
		clear_hists();
	endfunction

	always @(posedge clk) begin
		sig_pkg::result_t e;
		if (done) begin
			if (gain_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result gain=%0d status=%0b", result.gain, result.status);
			end else begin
				e = gain_q.pop_front();
				if (e.gain !== result.gain || e.status !== result.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp gain=%0d status=%0b, got gain=%0d status=%0b",
							e.gain, e.status, result.gain, result.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send(sig_pkg::sample_t s);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		score_sample(s);
	endtask

	task automatic send_fields(int label, logic [23:0] w, bit left, bit last);
		sig_pkg::sample_t s;
		s.class_label = 3'(label);
		s.sample_weight = w;
		s.goes_left = left;
		s.last_sample = last;
		send(s);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (gain_q.size() != 0 || busy)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_active(logic [3:0] val);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_ACTIVE;
		pwdata <= {28'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		labels_cfg = val;
	endtask

	task automatic test_directed();
		send_fields(3, 24'd0, 1'b1, 1'b1);            // empty set
		send_fields(0, 24'd512, 1'b1, 1'b0);          // right side empty
		send_fields(5, 24'd77, 1'b1, 1'b1);
		send_fields(0, 24'd256, 1'b1, 1'b0);
		send_fields(1, 24'd256, 1'b0, 1'b1);
		for (int l = 0; l < NLAB; l++)
			send_fields(l, 24'hFFFFFF, l[0], l == NLAB - 1);
		send_fields(7, 24'd1, 1'b0, 1'b0);
		send_fields(7, 24'h800000, 1'b1, 1'b0);
		send_fields(2, 24'h7FFFFF, 1'b0, 1'b1);
		drain();                                      // hold off until all results in
		write_active(4'd1);
		send_fields(0, 24'd1000, 1'b1, 1'b0);
		send_fields(0, 24'd3, 1'b0, 1'b0);
		send_fields(6, 24'd900, 1'b0, 1'b1);          // inactive label ignored in score
		write_active(4'd0);
		send_fields(0, 24'd10, 1'b1, 1'b0);
		send_fields(0, 24'd20, 1'b0, 1'b1);
		write_active(4'd15);
		send_fields(4, 24'h123456, 1'b1, 1'b0);
		send_fields(7, 24'h00ABCD, 1'b0, 1'b1);
		write_active(4'd3);
		send_fields(2, 24'd5000, 1'b1, 1'b0);
		send_fields(5, 24'd5000, 1'b0, 1'b1);         // right weight outside active set
	endtask

	function automatic logic [23:0] rand_weight();
		case ($urandom_range(7))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(1023));
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic test_random(int items, int pct, logic [3:0] act);
		int sent, len;
		sig_pkg::sample_t s;
		write_active(act);
		idle_pct = pct;
		sent = 0;
		while (sent < items) begin
			len = $urandom_range(24, 1);
			for (int i = 0; i < len; i++) begin
				s.class_label = 3'($urandom_range(NLAB - 1));
				s.sample_weight = rand_weight();
				s.goes_left = 1'($urandom_range(1));
				s.last_sample = (i == len - 1);
				if ($urandom_range(19) == 0)
					s.last_sample = 1'($urandom_range(1));
				send(s);
				sent++;
			end
		end
		idle_pct = 0;
	endtask

	initial begin
		clear_hists();
		labels_cfg = sig_pkg::ACT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(470, 33, 4'd8);
		test_random(470, 66, 4'd2);
		test_random(470, 0, 4'd5);
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && gain_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
